/* hdl/preamble_trailer_deframer_defines.svh */
// ----------------------------------------------------------------------------
// preamble_trailer_deframer_defines
// Assertion macros used by the deframer front end (ptd_front).
// ----------------------------------------------------------------------------
`ifndef PREAMBLE_TRAILER_DEFRAMER_DEFINES_SVH
`define PREAMBLE_TRAILER_DEFRAMER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define PTD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// expression must never be true outside reset
`define PTD_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

/* hdl/ptd_pkg.sv */
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and constants of the preamble/trailer deframer.
// ----------------------------------------------------------------------------
package ptd_pkg;

   localparam int BYTE_W  = 8;
   localparam int PLEN_W  = 4;
   localparam int WORD_W  = 32;
   localparam int IDX_W   = 6;
   localparam int CSR_W   = 2;
   localparam int Q_DEPTH = 2;

   localparam logic [BYTE_W-1:0] PREAMBLE_FF = 8'hFF;
   localparam logic [BYTE_W-1:0] PREAMBLE_AA = 8'hAA;
   localparam logic [PLEN_W-1:0] RUN_MAX     = 4'hF;
   localparam logic [PLEN_W-1:0] PLEN_RST    = 4'd4;
   localparam logic [WORD_W-1:0] TRAILER_RST = 32'hDEADBEEF;

   localparam logic [CSR_W-1:0] CSR_PREAMBLE_LEN = 2'd0;
   localparam logic [CSR_W-1:0] CSR_TRAILER_WORD = 2'd1;

   typedef enum logic {
      MODE_HUNT  = 1'b0,
      MODE_FRAME = 1'b1
   } mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              frame_kind;
      logic [IDX_W-1:0]  byte_index;
      logic              last;
      logic              overflow;
   } rsp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

/* hdl/ptd_req_if.sv */
// ----------------------------------------------------------------------------
// ptd_req_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface ptd_req_if;
   logic                      valid;
   logic                      ready;
   logic [ptd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hdl/ptd_rsp_if.sv */
// ----------------------------------------------------------------------------
// ptd_rsp_if
// Deframed byte channel.
// ----------------------------------------------------------------------------
interface ptd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ptd_pkg::BYTE_W-1:0] data_byte;
   logic                      frame_kind;
   logic [ptd_pkg::IDX_W-1:0]  byte_index;
   logic                      last;
   logic                      overflow;

   modport source (output valid, output data_byte, output frame_kind, output byte_index,
                   output last, output overflow, input ready);
   modport sink   (input valid, input data_byte, input frame_kind, input byte_index,
                   input last, input overflow, output ready);
endinterface

/* hdl/ptd_csr_if.sv */
// ----------------------------------------------------------------------------
// ptd_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface ptd_csr_if;
   logic                      valid;
   logic                      ready;
   logic [ptd_pkg::CSR_W-1:0]  idx;
   logic [ptd_pkg::WORD_W-1:0] wdata;

   modport source (output valid, output idx, output wdata, input ready);
   modport sink   (input valid, input idx, input wdata, output ready);
endinterface

/* hdl/ptd_front.sv */
// ----------------------------------------------------------------------------
// ptd_front
// Preamble hunt, frame tracking and trailer match; pushes one result per
// byte received inside a frame.
// ----------------------------------------------------------------------------
`include "preamble_trailer_deframer_defines.svh"

module ptd_front #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   ptd_req_if.sink                req_chan,
   ptd_csr_if.sink                csr_chan,
   input  ptd_pkg::q_stat_type    q_stat,
   output logic                   push,
   output ptd_pkg::rsp_item_type  push_item
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PAYLOAD - 1);

   ptd_pkg::mode_type              state_ff, state_in;
   logic [ptd_pkg::PLEN_W-1:0]     ff_run_ff, ff_run_in;
   logic [ptd_pkg::PLEN_W-1:0]     aa_run_ff, aa_run_in;
   logic                           kind_ff, kind_in;
   logic [1:0]                     tpos_ff, tpos_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [ptd_pkg::PLEN_W-1:0]     plen_ff, plen_in;
   logic [ptd_pkg::WORD_W-1:0]     trailer_ff, trailer_in;

   logic                           accept;
   logic                           csr_write;
   logic [ptd_pkg::BYTE_W-1:0]     rx;
   logic [ptd_pkg::BYTE_W-1:0]     tbyte;
   logic                           trl_done;
   logic                           ovf;
   logic                           frame_open;
   logic                           in_frame;

   assign req_chan.ready = !q_stat.full;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign rx             = req_chan.rx_byte;
   assign frame_open     = (state_ff == ptd_pkg::MODE_HUNT) && (state_in == ptd_pkg::MODE_FRAME);
   assign in_frame       = (state_ff == ptd_pkg::MODE_FRAME);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ptd_pkg::MODE_HUNT;
         ff_run_ff  <= '0;
         aa_run_ff  <= '0;
         kind_ff    <= 1'b0;
         tpos_ff    <= '0;
         count_ff   <= '0;
         plen_ff    <= ptd_pkg::PLEN_RST;
         trailer_ff <= ptd_pkg::TRAILER_RST;
      end else begin
         state_ff   <= state_in;
         ff_run_ff  <= ff_run_in;
         aa_run_ff  <= aa_run_in;
         kind_ff    <= kind_in;
         tpos_ff    <= tpos_in;
         count_ff   <= count_in;
         plen_ff    <= plen_in;
         trailer_ff <= trailer_in;
      end
   end

   always_comb begin
      plen_in    = plen_ff;
      trailer_in = trailer_ff;
      if (csr_write) begin
         case (csr_chan.idx)
            ptd_pkg::CSR_PREAMBLE_LEN: plen_in    = csr_chan.wdata[ptd_pkg::PLEN_W-1:0];
            ptd_pkg::CSR_TRAILER_WORD: trailer_in = csr_chan.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (tpos_ff)
         2'd0:    tbyte = trailer_ff[31:24];
         2'd1:    tbyte = trailer_ff[23:16];
         2'd2:    tbyte = trailer_ff[15:8];
         default: tbyte = trailer_ff[7:0];
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      ff_run_in = ff_run_ff;
      aa_run_in = aa_run_ff;
      kind_in   = kind_ff;
      tpos_in   = tpos_ff;
      count_in  = count_ff;
      push      = 1'b0;
      trl_done  = 1'b0;
      ovf       = 1'b0;

      push_item.data_byte  = rx;
      push_item.frame_kind = kind_ff;
      push_item.byte_index = ptd_pkg::IDX_W'(count_ff);
      push_item.last       = 1'b0;
      push_item.overflow   = 1'b0;

      if (accept) begin
         case (state_ff)
            ptd_pkg::MODE_HUNT: begin
               if (rx == ptd_pkg::PREAMBLE_FF) begin
                  if (ff_run_ff != ptd_pkg::RUN_MAX) ff_run_in = ff_run_ff + 4'd1;
                  aa_run_in = '0;
               end else if (rx == ptd_pkg::PREAMBLE_AA) begin
                  if (aa_run_ff != ptd_pkg::RUN_MAX) aa_run_in = aa_run_ff + 4'd1;
                  ff_run_in = '0;
               end else begin
                  ff_run_in = '0;
                  aa_run_in = '0;
               end
               if (ff_run_in != '0 && ff_run_in >= plen_ff) begin
                  state_in = ptd_pkg::MODE_FRAME;
                  kind_in  = 1'b0;
               end else if (aa_run_in != '0 && aa_run_in >= plen_ff) begin
                  state_in = ptd_pkg::MODE_FRAME;
                  kind_in  = 1'b1;
               end
               if (state_in == ptd_pkg::MODE_FRAME) begin
                  tpos_in   = '0;
                  count_in  = '0;
                  ff_run_in = '0;
                  aa_run_in = '0;
               end
            end
            ptd_pkg::MODE_FRAME: begin
               push = 1'b1;
               if (rx == tbyte) begin
                  if (tpos_ff == 2'd3) trl_done = 1'b1;
                  else                 tpos_in  = tpos_ff + 2'd1;
               end else begin
                  tpos_in = (rx == trailer_ff[31:24]) ? 2'd1 : 2'd0;
               end
               count_in = count_ff + CNT_W'(1);
               ovf      = !trl_done && (count_ff == CNT_LAST);
               push_item.last     = trl_done || ovf;
               push_item.overflow = ovf;
               if (trl_done || ovf) begin
                  state_in  = ptd_pkg::MODE_HUNT;
                  kind_in   = 1'b0;
                  tpos_in   = '0;
                  count_in  = '0;
                  ff_run_in = '0;
                  aa_run_in = '0;
               end
            end
            default: state_in = ptd_pkg::MODE_HUNT;
         endcase
      end
   end

   `PTD_NEVER(a_push_full, push && q_stat.full, "push into a full queue")
   `PTD_ASSERT(a_ovf_last, (push && push_item.overflow) |-> push_item.last, "overflow without last")
   `PTD_ASSERT(a_open_clear, frame_open |=> count_ff == '0 && tpos_ff == '0, "stale frame state")
   `PTD_NEVER(a_run_in_frame, in_frame && (ff_run_ff | aa_run_ff) != '0, "run count in frame")

endmodule

/* hdl/ptd_fifo.sv */
// ----------------------------------------------------------------------------
// ptd_fifo
// Short queue between the framer and the output stage.
// ----------------------------------------------------------------------------
module ptd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ptd_pkg::rsp_item_type  push_item,
   input  logic                   pop,
   output ptd_pkg::rsp_item_type  head_item,
   output ptd_pkg::q_stat_type    q_stat
);

   localparam int PTR_W = $clog2(ptd_pkg::Q_DEPTH);
   localparam int CNT_W = $clog2(ptd_pkg::Q_DEPTH + 1);

   ptd_pkg::rsp_item_type  entry_ff [ptd_pkg::Q_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == CNT_W'(ptd_pkg::Q_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign head_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop)      cnt_in = cnt_ff + CNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

/* hdl/ptd_back.sv */
// ----------------------------------------------------------------------------
// ptd_back
// Output register stage; drains the queue onto the result channel.
// ----------------------------------------------------------------------------
module ptd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ptd_pkg::rsp_item_type  head_item,
   input  ptd_pkg::q_stat_type    q_stat,
   output logic                   pop,
   ptd_rsp_if.source              rsp_chan
);

   logic                   valid_ff, valid_in;
   ptd_pkg::rsp_item_type  item_ff;

   assign pop      = !q_stat.empty && (!valid_ff || rsp_chan.ready);
   assign valid_in = pop || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) item_ff <= head_item;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.data_byte  = item_ff.data_byte;
   assign rsp_chan.frame_kind = item_ff.frame_kind;
   assign rsp_chan.byte_index = item_ff.byte_index;
   assign rsp_chan.last       = item_ff.last;
   assign rsp_chan.overflow   = item_ff.overflow;

endmodule

/* hdl/preamble_trailer_deframer.sv */
// A frame byte accepted on req goes through the queue and the output register to rsp.
// Throughput: one byte per cycle; req_chan.ready drops only while the two-entry queue
// between the framer and the output register is full.
// Hunt-phase and preamble bytes produce no result.
// Reset: synchronous; clears framer state, queue and output stage, and restores
// preamble_len to 4 and trailer_word to 0xDEADBEEF.
// ----------------------------------------------------------------------------
// preamble_trailer_deframer
// Byte-serial frame extractor: preamble hunt, payload pass-through, trailer
// match and payload limit.
// ----------------------------------------------------------------------------
module preamble_trailer_deframer #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic        clock,
   input  logic        reset,
   ptd_req_if.sink     req_chan,
   ptd_rsp_if.source   rsp_chan,
   ptd_csr_if.sink     csr_chan
);

   logic                   push;
   logic                   pop;
   ptd_pkg::rsp_item_type  push_item;
   ptd_pkg::rsp_item_type  head_item;
   ptd_pkg::q_stat_type    q_stat;

   ptd_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   ptd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   ptd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
